@@ rtl/rsbc_pkg.sv @@
package rsbc_pkg;

  localparam int COORD_BITS   = 32;
  localparam int TOL_BITS     = 16;
  localparam int TOL_RESET    = 655;
  localparam int CFG_IDX_BITS = 3;
  localparam int IN_W         = 6 * COORD_BITS;
  localparam int OUT_W        = 8;

  localparam int DIF_W      = COORD_BITS + 1;
  localparam int MAG_W      = COORD_BITS + 1;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int PT_W       = COORD_BITS + 3;
  localparam int DIV_STAGES = MAG_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIF_W-1:0]      dif_t;
  typedef logic        [MAG_W-1:0]      mag_t;
  typedef logic        [PROD_W-1:0]     prod_t;
  typedef logic signed [PT_W-1:0]       pt_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_END_X,
    REG_END_Y,
    REG_END_Z,
    REG_TOLERANCE
  } reg_idx_e;

  typedef struct packed {
    coord_t [2:0]        s;
    coord_t [2:0]        e;
    logic [TOL_BITS-1:0] tol;
  } seg_cfg_t;

  typedef struct packed {
    logic             rej;
    logic             zero;
    axis_e            ax;
    dif_t [1:0]       d;
    logic [1:0][1:0]  neg;
    coord_t [2:0]     lo;
    coord_t [2:0]     hi;
  } side_t;

  typedef struct packed {
    logic rej;
    logic zero;
  } stat_t;

  function automatic axis_e other_axis(axis_e ax, logic sel);
    axis_e r;
    unique case (ax)
      AXIS_X:  r = sel ? AXIS_Z : AXIS_Y;
      AXIS_Y:  r = sel ? AXIS_Z : AXIS_X;
      default: r = sel ? AXIS_Y : AXIS_X;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/rsbc_front.sv @@
module rsbc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  rsbc_pkg::coord_t [2:0]     box_lo_i,
  input  rsbc_pkg::coord_t [2:0]     box_hi_i,
  input  rsbc_pkg::seg_cfg_t         cfg_i,
  output logic                       valid_o,
  output rsbc_pkg::side_t            side_o,
  output rsbc_pkg::prod_t [1:0][1:0] prod_o,
  output rsbc_pkg::mag_t             den_o
);

  logic [3:0] vld_q;

  rsbc_pkg::dif_t   [2:0] v1_q;
  rsbc_pkg::coord_t [2:0] lo1_q, hi1_q, lo2_q, hi2_q, lo3_q, hi3_q;
  logic                   rej1_q, rej2_q, rej3_q;

  rsbc_pkg::axis_e        ax2_q, ax3_q;
  rsbc_pkg::mag_t   [2:0] mv2_q;
  logic             [2:0] sg2_q;

  rsbc_pkg::dif_t   [1:0] d3_q;
  rsbc_pkg::mag_t   [1:0] md3_q;
  rsbc_pkg::mag_t   [1:0] mb3_q;
  rsbc_pkg::mag_t         den3_q;
  logic                   zero3_q;
  logic [1:0][1:0]        neg3_q;

  rsbc_pkg::prod_t [1:0][1:0] prod4_q;
  rsbc_pkg::mag_t             den4_q;
  rsbc_pkg::side_t            side4_q;

  rsbc_pkg::dif_t   [2:0] v1_d;
  logic                   rej1_d;
  rsbc_pkg::mag_t   [2:0] mv2_d;
  logic             [2:0] sg2_d;
  rsbc_pkg::axis_e        ax2_d;
  rsbc_pkg::dif_t   [1:0] d3_d;
  rsbc_pkg::mag_t   [1:0] md3_d;
  rsbc_pkg::mag_t   [1:0] mb3_d;
  logic [1:0][1:0]        neg3_d;
  logic                   zero3_d;
  rsbc_pkg::prod_t [1:0][1:0] prod4_d;

  always_comb begin
    rej1_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v1_d[i] = rsbc_pkg::dif_t'(cfg_i.e[i]) - rsbc_pkg::dif_t'(cfg_i.s[i]);
      if ((cfg_i.s[i] < box_lo_i[i]) && (cfg_i.e[i] < box_lo_i[i])) begin
        rej1_d = 1'b1;
      end
      if ((cfg_i.s[i] > box_hi_i[i]) && (cfg_i.e[i] > box_hi_i[i])) begin
        rej1_d = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sg2_d[i] = v1_q[i][rsbc_pkg::DIF_W-1];
      mv2_d[i] = rsbc_pkg::mag_t'(sg2_d[i] ? -v1_q[i] : v1_q[i]);
    end
    priority if ((mv2_d[0] >= mv2_d[1]) && (mv2_d[0] >= mv2_d[2])) begin
      ax2_d = rsbc_pkg::AXIS_X;
    end else if (mv2_d[1] >= mv2_d[2]) begin
      ax2_d = rsbc_pkg::AXIS_Y;
    end else begin
      ax2_d = rsbc_pkg::AXIS_Z;
    end
  end

  always_comb begin
    logic           vs;
    logic           vz;
    logic           dn;
    logic           dpos;
    rsbc_pkg::dif_t draw;
    vs      = sg2_q[ax2_q];
    vz      = (mv2_q[ax2_q] == '0);
    zero3_d = vz;
    for (int k = 0; k < 2; k++) begin
      draw = rsbc_pkg::dif_t'((k == 0) ? hi2_q[ax2_q] : lo2_q[ax2_q])
           - rsbc_pkg::dif_t'(cfg_i.s[ax2_q]);
      dn   = draw[rsbc_pkg::DIF_W-1];
      dpos = !dn && (draw != '0);
      if ((dn && !vs && !vz) || (dpos && vs)) begin
        draw = '0;
        dn   = 1'b0;
      end
      d3_d[k]  = draw;
      md3_d[k] = rsbc_pkg::mag_t'(dn ? -draw : draw);
      for (int j = 0; j < 2; j++) begin
        neg3_d[k][j] = sg2_q[rsbc_pkg::other_axis(ax2_q, 1'(j))] ^ dn ^ vs;
      end
    end
    for (int j = 0; j < 2; j++) begin
      mb3_d[j] = mv2_q[rsbc_pkg::other_axis(ax2_q, 1'(j))];
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 2; j++) begin
        prod4_d[k][j] = rsbc_pkg::prod_t'(mb3_q[j]) * rsbc_pkg::prod_t'(md3_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      v1_q   <= v1_d;
      lo1_q  <= box_lo_i;
      hi1_q  <= box_hi_i;
      rej1_q <= rej1_d;

      mv2_q  <= mv2_d;
      sg2_q  <= sg2_d;
      ax2_q  <= ax2_d;
      lo2_q  <= lo1_q;
      hi2_q  <= hi1_q;
      rej2_q <= rej1_q;

      d3_q    <= d3_d;
      md3_q   <= md3_d;
      mb3_q   <= mb3_d;
      neg3_q  <= neg3_d;
      zero3_q <= zero3_d;
      den3_q  <= zero3_d ? rsbc_pkg::mag_t'(1) : mv2_q[ax2_q];
      ax3_q   <= ax2_q;
      lo3_q   <= lo2_q;
      hi3_q   <= hi2_q;
      rej3_q  <= rej2_q;

      prod4_q      <= prod4_d;
      den4_q       <= den3_q;
      side4_q.rej  <= rej3_q;
      side4_q.zero <= zero3_q;
      side4_q.ax   <= ax3_q;
      side4_q.d    <= d3_q;
      side4_q.neg  <= neg3_q;
      side4_q.lo   <= lo3_q;
      side4_q.hi   <= hi3_q;
    end
  end

  assign valid_o = vld_q[3];
  assign side_o  = side4_q;
  assign prod_o  = prod4_q;
  assign den_o   = den4_q;

endmodule

@@ rtl/rsbc_div.sv @@
module rsbc_div (
  input  logic            clk_i,
  input  logic            adv_i,
  input  rsbc_pkg::prod_t prod_i,
  input  rsbc_pkg::mag_t  den_i,
  output rsbc_pkg::mag_t  quo_o
);

  rsbc_pkg::mag_t rem_q  [rsbc_pkg::DIV_STAGES];
  rsbc_pkg::mag_t work_q [rsbc_pkg::DIV_STAGES];
  rsbc_pkg::mag_t den_q  [rsbc_pkg::DIV_STAGES];

  for (genvar s = 0; s < rsbc_pkg::DIV_STAGES; s++) begin : g_step
    rsbc_pkg::mag_t          rem_in;
    rsbc_pkg::mag_t          work_in;
    rsbc_pkg::mag_t          den_in;
    logic [rsbc_pkg::MAG_W:0] t;
    logic [rsbc_pkg::MAG_W:0] diff;
    logic                     ge;

    if (s == 0) begin : g_first
      assign rem_in  = prod_i[rsbc_pkg::PROD_W-1:rsbc_pkg::MAG_W];
      assign work_in = prod_i[rsbc_pkg::MAG_W-1:0];
      assign den_in  = den_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign work_in = work_q[s-1];
      assign den_in  = den_q[s-1];
    end

    assign t    = {rem_in, work_in[rsbc_pkg::MAG_W-1]};
    assign diff = t - {1'b0, den_in};
    assign ge   = (t >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= ge ? diff[rsbc_pkg::MAG_W-1:0] : t[rsbc_pkg::MAG_W-1:0];
        work_q[s] <= {work_in[rsbc_pkg::MAG_W-2:0], ge};
        den_q[s]  <= den_in;
      end
    end
  end

  assign quo_o = work_q[rsbc_pkg::DIV_STAGES-1];

endmodule

@@ rtl/rsbc_back.sv @@
module rsbc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  rsbc_pkg::side_t           side_i,
  input  rsbc_pkg::mag_t [1:0][1:0] quo_i,
  input  rsbc_pkg::seg_cfg_t        cfg_i,
  output logic                      valid_o,
  output logic                      may_cross_o,
  output rsbc_pkg::stat_t           stat_o
);

  logic                 vld_q;
  rsbc_pkg::pt_t [1:0][2:0] pt_q, pt_d;
  rsbc_pkg::pt_t [2:0]  lw_q, hw_q, lw_d, hw_d;
  rsbc_pkg::stat_t      stat_q;
  logic                 overlap;

  always_comb begin
    rsbc_pkg::pt_t sq;
    logic          sel;
    sel = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lw_d[i] = rsbc_pkg::pt_t'(side_i.lo[i]) - rsbc_pkg::pt_t'(cfg_i.tol);
      hw_d[i] = rsbc_pkg::pt_t'(side_i.hi[i]) + rsbc_pkg::pt_t'(cfg_i.tol);
      sel     = (rsbc_pkg::other_axis(side_i.ax, 1'b1) == rsbc_pkg::axis_e'(i));
      for (int k = 0; k < 2; k++) begin
        sq = rsbc_pkg::pt_t'(quo_i[k][sel]);
        if (side_i.neg[k][sel]) begin
          sq = -sq;
        end
        if (side_i.ax == rsbc_pkg::axis_e'(i)) begin
          pt_d[k][i] = rsbc_pkg::pt_t'(cfg_i.s[i]) + rsbc_pkg::pt_t'(side_i.d[k]);
        end else begin
          pt_d[k][i] = rsbc_pkg::pt_t'(cfg_i.s[i]) + sq;
        end
      end
    end
  end

  always_comb begin
    rsbc_pkg::pt_t pmin;
    rsbc_pkg::pt_t pmax;
    overlap = 1'b1;
    for (int i = 0; i < 3; i++) begin
      pmin = (pt_q[0][i] < pt_q[1][i]) ? pt_q[0][i] : pt_q[1][i];
      pmax = (pt_q[0][i] < pt_q[1][i]) ? pt_q[1][i] : pt_q[0][i];
      if ((lw_q[i] > pmax) || (hw_q[i] < pmin)) begin
        overlap = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pt_q        <= pt_d;
      lw_q        <= lw_d;
      hw_q        <= hw_d;
      stat_q.rej  <= side_i.rej;
      stat_q.zero <= side_i.zero;
    end
  end

  assign valid_o     = vld_q;
  assign stat_o      = stat_q;
  assign may_cross_o = !stat_q.rej && (stat_q.zero || overlap);

endmodule

@@ rtl/ray_segment_box_cull.sv @@
// Pipeline: an accepted box reaches its result on the output register through
// 4 setup stages, one stage per quotient bit in the divider, 1 clip stage, output.
// Throughput: one box per cycle; all stages hold together while the output stalls.
// Reset: asynchronous active low; clears valid bits and sets the segment to zero
// and tolerance to 655.
module ray_segment_box_cull (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z
  input  logic [rsbc_pkg::IN_W-1:0]          s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // may_cross, then zero fill
  output logic [rsbc_pkg::OUT_W-1:0]         m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rsbc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [rsbc_pkg::COORD_BITS-1:0]    cfg_data_i
);

  localparam int CB = rsbc_pkg::COORD_BITS;

  rsbc_pkg::seg_cfg_t cfg_q;
  logic               adv;
  logic               out_vld_q;
  logic               may_cross_q;

  rsbc_pkg::coord_t [2:0] box_lo, box_hi;

  logic                        fr_vld;
  rsbc_pkg::side_t             fr_side;
  rsbc_pkg::prod_t [1:0][1:0]  fr_prod;
  rsbc_pkg::mag_t              fr_den;
  rsbc_pkg::mag_t  [1:0][1:0]  quo;

  logic            [rsbc_pkg::DIV_STAGES-1:0] dl_vld_q;
  rsbc_pkg::side_t                            dl_side_q [rsbc_pkg::DIV_STAGES];

  logic            bk_vld;
  logic            bk_may;
  rsbc_pkg::stat_t bk_stat;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign box_lo[i] = s_axis_tdata[i*CB +: CB];
    assign box_hi[i] = s_axis_tdata[(i+3)*CB +: CB];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.s   <= '0;
      cfg_q.e   <= '0;
      cfg_q.tol <= rsbc_pkg::TOL_BITS'(rsbc_pkg::TOL_RESET);
    end else if (cfg_valid_i) begin
      unique case (rsbc_pkg::reg_idx_e'(cfg_index_i))
        rsbc_pkg::REG_START_X:   cfg_q.s[0] <= cfg_data_i;
        rsbc_pkg::REG_START_Y:   cfg_q.s[1] <= cfg_data_i;
        rsbc_pkg::REG_START_Z:   cfg_q.s[2] <= cfg_data_i;
        rsbc_pkg::REG_END_X:     cfg_q.e[0] <= cfg_data_i;
        rsbc_pkg::REG_END_Y:     cfg_q.e[1] <= cfg_data_i;
        rsbc_pkg::REG_END_Z:     cfg_q.e[2] <= cfg_data_i;
        rsbc_pkg::REG_TOLERANCE: cfg_q.tol  <= cfg_data_i[rsbc_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  rsbc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (s_axis_tvalid),
    .box_lo_i (box_lo),
    .box_hi_i (box_hi),
    .cfg_i    (cfg_q),
    .valid_o  (fr_vld),
    .side_o   (fr_side),
    .prod_o   (fr_prod),
    .den_o    (fr_den)
  );

  for (genvar k = 0; k < 2; k++) begin : g_plane
    for (genvar j = 0; j < 2; j++) begin : g_axis
      rsbc_div u_div (
        .clk_i  (clk_i),
        .adv_i  (adv),
        .prod_i (fr_prod[k][j]),
        .den_i  (fr_den),
        .quo_o  (quo[k][j])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_vld_q <= '0;
    end else if (adv) begin
      dl_vld_q <= {dl_vld_q[rsbc_pkg::DIV_STAGES-2:0], fr_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_side_q[0] <= fr_side;
      for (int s = 1; s < rsbc_pkg::DIV_STAGES; s++) begin
        dl_side_q[s] <= dl_side_q[s-1];
      end
    end
  end

  rsbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (dl_vld_q[rsbc_pkg::DIV_STAGES-1]),
    .side_i      (dl_side_q[rsbc_pkg::DIV_STAGES-1]),
    .quo_i       (quo),
    .cfg_i       (cfg_q),
    .valid_o     (bk_vld),
    .may_cross_o (bk_may),
    .stat_o      (bk_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= bk_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      may_cross_q <= bk_may;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(rsbc_pkg::OUT_W-1){1'b0}}, may_cross_q};

`ifndef SYNTHESIS
  a_reject_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && bk_vld && bk_stat.rej) |=> (out_vld_q && !may_cross_q))
    else $error("early-rejected box reported as crossing");

  a_point_is_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && bk_vld && !bk_stat.rej && bk_stat.zero) |=> (out_vld_q && may_cross_q))
    else $error("zero-length segment inside box reported as miss");
`endif

endmodule

@@ dv/tb_ray_segment_box_cull.sv @@
module tb_ray_segment_box_cull;

  typedef struct {
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
  } box_t;

  typedef struct {
    logic               is_cfg;
    rsbc_pkg::reg_idx_e idx;
    logic [31:0]        data;
    box_t               box;
  } pend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [rsbc_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [rsbc_pkg::OUT_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rsbc_pkg::CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [rsbc_pkg::COORD_BITS-1:0] cfg_data_i = '0;

  ray_segment_box_cull uut (.*);

  always #6 clk_i = ~clk_i;

  pend_t pending[$];
  logic [rsbc_pkg::OUT_W-1:0] cross_q[$];
  int errors = 0;
  int cycles = 0;
  int s_wait = 0;
  int m_wait = 0;
  int quiet = 0;
  bit fed_done = 0;
  bit in_taken = 0;
  bit out_taken = 0;
  box_t cur_box;

  logic signed [63:0] seg_s [3] = '{default: 64'sd0};
  logic signed [63:0] seg_e [3] = '{default: 64'sd0};
  logic [15:0] seg_tol = 16'(rsbc_pkg::TOL_RESET);

  task automatic report(string what, logic [rsbc_pkg::OUT_W-1:0] got,
                        logic [rsbc_pkg::OUT_W-1:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic signed [63:0] clip_scale(logic signed [63:0] n1,
                                                    logic signed [63:0] n2,
                                                    logic signed [63:0] den);
    logic signed [127:0] p;
    p = 128'(n1) * 128'(n2);
    return 64'(p / 128'(den));
  endfunction

  function automatic logic predict_cross(box_t b);
    logic signed [63:0] lo [3], hi [3], v [3], mg [3];
    logic signed [63:0] pt [2][3];
    logic signed [63:0] d, pmin, pmax, tol;
    int ax;
    tol = 64'(seg_tol);
    for (int i = 0; i < 3; i++) begin
      lo[i] = b.lo[i];
      hi[i] = b.hi[i];
      if (seg_s[i] < lo[i] && seg_e[i] < lo[i]) return 1'b0;
      if (seg_s[i] > hi[i] && seg_e[i] > hi[i]) return 1'b0;
      v[i] = seg_e[i] - seg_s[i];
      mg[i] = v[i] < 0 ? -v[i] : v[i];
    end
    if (mg[0] >= mg[1] && mg[0] >= mg[2]) ax = 0;
    else if (mg[1] >= mg[2]) ax = 1;
    else ax = 2;
    if (v[ax] == 0) return 1'b1;
    for (int k = 0; k < 2; k++) begin
      d = (k == 0 ? hi[ax] : lo[ax]) - seg_s[ax];
      if ((d < 0 && v[ax] > 0) || (d > 0 && v[ax] < 0)) d = 0;
      for (int i = 0; i < 3; i++)
        pt[k][i] = (i == ax) ? seg_s[i] + d : seg_s[i] + clip_scale(v[i], d, v[ax]);
    end
    for (int i = 0; i < 3; i++) begin
      pmin = pt[0][i] < pt[1][i] ? pt[0][i] : pt[1][i];
      pmax = pt[0][i] < pt[1][i] ? pt[1][i] : pt[0][i];
      if (lo[i] - tol > pmax || hi[i] + tol < pmin) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] rnd_coord();
    unique case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_fffc + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  task automatic add_cfg(rsbc_pkg::reg_idx_e idx, logic [31:0] val);
    pend_t p;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.data = val;
    pending.push_back(p);
  endtask

  task automatic add_box(logic [31:0] c [6]);
    pend_t p;
    p.is_cfg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p.box.lo[i] = c[i];
      p.box.hi[i] = c[i + 3];
    end
    pending.push_back(p);
  endtask

  task automatic add_rand_box(bit well);
    logic [31:0] c [6];
    logic signed [31:0] a, w;
    for (int i = 0; i < 3; i++) begin
      if (well) begin
        a = 32'($signed($urandom_range(0, 30 << 16)) - (15 << 16));
        w = $urandom_range(0, 8 << 16);
        c[i] = a;
        c[i + 3] = a + w;
      end else begin
        c[i] = rnd_coord();
        c[i + 3] = rnd_coord();
      end
    end
    add_box(c);
  endtask

  task automatic add_rand_segment(bit wide);
    for (int i = 0; i < 6; i++)
      add_cfg(rsbc_pkg::reg_idx_e'(i), wide ? rnd_coord()
              : 32'($signed($urandom_range(0, 30 << 16)) - (15 << 16)));
    add_cfg(rsbc_pkg::REG_TOLERANCE,
            $urandom_range(0, 2) == 0 ? 32'hffff : $urandom_range(0, 2000));
  endtask

  initial begin
    logic [31:0] c [6];
    for (int i = 0; i < 3; i++) begin
      c[i] = 32'h8000_0000;
      c[i + 3] = 32'h7fff_ffff;
    end
    add_box(c);
    for (int i = 0; i < 6; i++) c[i] = 32'h0001_0000;
    add_box(c);
    for (int i = 0; i < 3; i++) begin
      c[i] = 32'h0000_0000;
      c[i + 3] = 32'hffff_ffff;
    end
    add_box(c);
    add_cfg(rsbc_pkg::REG_START_X, 32'h8000_0000);
    add_cfg(rsbc_pkg::REG_START_Y, 32'h8000_0000);
    add_cfg(rsbc_pkg::REG_START_Z, 32'h7fff_ffff);
    add_cfg(rsbc_pkg::REG_END_X, 32'h7fff_ffff);
    add_cfg(rsbc_pkg::REG_END_Y, 32'h7fff_ffff);
    add_cfg(rsbc_pkg::REG_END_Z, 32'h8000_0000);
    add_cfg(rsbc_pkg::REG_TOLERANCE, 32'h0000_ffff);
    for (int i = 0; i < 3; i++) begin
      c[i] = 32'h8000_0000;
      c[i + 3] = 32'h7fff_ffff;
    end
    add_box(c);
    for (int i = 0; i < 3; i++) begin
      c[i] = 32'h0000_0000;
      c[i + 3] = 32'h0001_0000;
    end
    add_box(c);
    c[0] = 32'h7fff_ffff;
    c[3] = 32'h8000_0000;
    add_box(c);
    add_cfg(rsbc_pkg::REG_TOLERANCE, 32'h0);
    for (int i = 0; i < 10; i++) add_rand_box(i[0]);
    for (int i = 0; i < 6; i++) add_cfg(rsbc_pkg::reg_idx_e'(i), 32'h0002_0000);
    add_rand_box(1);
    add_rand_box(0);
    for (int ph = 0; ph < 30; ph++) begin
      add_rand_segment(ph % 5 == 0);
      if (ph % 7 == 3) begin
        add_cfg(rsbc_pkg::REG_END_X, 32'h0003_0000);
        add_cfg(rsbc_pkg::REG_END_Y, 32'h0003_0000);
        add_cfg(rsbc_pkg::REG_END_Z, 32'h0003_0000);
        add_cfg(rsbc_pkg::REG_START_X, 32'h0003_0000);
        add_cfg(rsbc_pkg::REG_START_Y, 32'h0003_0000);
        add_cfg(rsbc_pkg::REG_START_Z, 32'h0003_0000);
      end
      for (int i = 0; i < 50; i++) add_rand_box($urandom_range(0, 4) != 0);
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        s_axis_tvalid <= 1'b0;
        s_wait = $urandom_range(0, 5);
      end else if (cfg_valid_i && cfg_ready_o) begin
        cfg_valid_i <= 1'b0;
      end else if (!s_axis_tvalid && !cfg_valid_i) begin
        if (s_wait > 0) begin
          s_wait--;
        end else if (pending.size() > 0) begin
          if (pending[0].is_cfg) begin
            if (cross_q.size() == 0) begin
              if (quiet >= 45) begin
                cfg_valid_i <= 1'b1;
                cfg_index_i <= pending[0].idx;
                cfg_data_i <= pending[0].data;
                unique case (pending[0].idx)
                  rsbc_pkg::REG_START_X, rsbc_pkg::REG_START_Y, rsbc_pkg::REG_START_Z:
                    seg_s[pending[0].idx] = $signed(pending[0].data);
                  rsbc_pkg::REG_TOLERANCE: seg_tol = pending[0].data[15:0];
                  default:
                    seg_e[pending[0].idx - rsbc_pkg::REG_END_X] = $signed(pending[0].data);
                endcase
                void'(pending.pop_front());
              end
            end
          end else begin
            s_axis_tvalid <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              s_axis_tdata[i*32 +: 32] <= pending[0].box.lo[i];
              s_axis_tdata[(i+3)*32 +: 32] <= pending[0].box.hi[i];
            end
            cur_box = pending[0].box;
            void'(pending.pop_front());
          end
        end else begin
          fed_done = 1;
        end
      end
      if (out_taken) begin
        m_wait = $urandom_range(0, 5);
      end
      if (m_wait > 0) begin
        m_axis_tready <= 1'b0;
        m_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    in_taken = s_axis_tvalid && s_axis_tready;
    out_taken = m_axis_tvalid && m_axis_tready;
    if (in_taken) begin
      cross_q.push_back(rsbc_pkg::OUT_W'(predict_cross(cur_box)));
      quiet = 0;
    end else begin
      quiet++;
    end
    if (out_taken) begin
      if (cross_q.size() == 0) begin
        report("unexpected result", m_axis_tdata, '0);
      end else begin
        if (m_axis_tdata !== cross_q[0]) report("may_cross", m_axis_tdata, cross_q[0]);
        void'(cross_q.pop_front());
      end
    end
    if (fed_done && cross_q.size() == 0 && quiet > 60) begin
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
endmodule
